[rtl/text_console_char_writer_macros.svh]
// assertion macros for the text console character writer
// used by the sequencer; no dependencies
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("tcw assertion failed");
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcw assertion failed");
`else
`define TCW_ASSERT(label, clk, rst, expr)
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/tcw_pkg.sv]
// types, constants and address helper for the text console character writer
// no dependencies
package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;

   localparam logic       ACTION_PUT   = 1'b0;
   localparam logic       ACTION_READ  = 1'b1;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'h20;
   localparam logic [7:0] RESET_COLOR  = 8'h07;

   typedef struct packed {
      logic             action;
      logic [7:0]       char_code;
      logic [ROW_W-1:0] read_row;
      logic [COL_W-1:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0]       cell_char;
      logic [7:0]       cell_color;
      logic [ROW_W-1:0] cursor_row;
      logic [COL_W-1:0] cursor_col;
   } rsp_type;

   typedef struct packed {
      logic [7:0] color;
      logic [7:0] code;
   } cell_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      cell_type          data;
   } mem_wr_type;

   typedef struct packed {
      logic              re;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } rsp_push_type;

   // screen rows live in a ring; top is the physical row shown as row 0
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] top);
      logic [ROW_W:0] sum;
      logic [ROW_W:0] phys;
      sum = {1'b0, row} + {1'b0, top};
      if (sum >= (ROW_W+1)'(ROWS)) begin
         phys = sum - (ROW_W+1)'(ROWS);
      end else begin
         phys = sum;
      end
      return ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

[rtl/tcw_screen_ram.sv]
// screen cell memory: one write port, one read port with registered data
// depends on tcw_pkg
module tcw_screen_ram (
   input  logic                clock,
   input  tcw_pkg::mem_wr_type wr,
   input  tcw_pkg::mem_rd_type rd,
   output tcw_pkg::cell_type   rd_data
);
   import tcw_pkg::*;

   cell_type mem [CELL_COUNT];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.re) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tcw_seq.sv]
// sequencer: cursor, ring offset, color register, clearing sweeps and memory access
// depends on tcw_pkg and text_console_char_writer_macros.svh
module tcw_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tcw_pkg::req_type      req_data,
   input  logic                  csr_we,
   input  logic [7:0]            csr_wdata,
   input  logic                  out_free,
   output tcw_pkg::rsp_push_type push,
   output tcw_pkg::mem_wr_type   mem_wr,
   output tcw_pkg::mem_rd_type   mem_rd,
   input  tcw_pkg::cell_type     mem_rd_data
);
   import tcw_pkg::*;
   `include "text_console_char_writer_macros.svh"

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_RD_WAIT
   } state_type;

   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [7:0]        attr_ff, attr_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [ADDR_W-1:0] clr_last_ff, clr_last_in;
   logic [7:0]        clr_color_ff, clr_color_in;
   logic              rd_zero_ff, rd_zero_in;
   logic              accept;
   logic [ADDR_W-1:0] top_base;

   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign top_base  = ADDR_W'(top_ff) * ADDR_W'(COLUMNS);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      top_in       = top_ff;
      attr_in      = csr_we ? csr_wdata : attr_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_last_in  = clr_last_ff;
      clr_color_in = clr_color_ff;
      rd_zero_in   = rd_zero_ff;
      push         = '0;
      mem_wr       = '0;
      mem_rd       = '0;

      case (state_ff)
         ST_SWEEP: begin
            mem_wr.we        = 1'b1;
            mem_wr.addr      = clr_cnt_ff;
            mem_wr.data.code  = SPACE_CODE;
            mem_wr.data.color = clr_color_ff;
            if (clr_cnt_ff == clr_last_ff) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACTION_READ) begin
                  mem_rd.re   = 1'b1;
                  mem_rd.addr = cell_addr(req_data.read_row, req_data.read_col, top_ff);
                  rd_zero_in  = (req_data.read_row >= ROW_W'(ROWS)) ||
                                (req_data.read_col >= COL_W'(COLUMNS));
                  state_in    = ST_RD_WAIT;
               end else if (req_data.char_code == NEWLINE_CODE) begin
                  col_in = '0;
                  if (row_ff == ROW_W'(ROWS - 1)) begin
                     // scroll: advance the ring, clear the row that becomes the bottom
                     top_in       = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + ROW_W'(1);
                     clr_cnt_in   = top_base;
                     clr_last_in  = top_base + ADDR_W'(COLUMNS - 1);
                     clr_color_in = attr_ff;
                     state_in     = ST_SWEEP;
                  end else begin
                     row_in = row_ff + ROW_W'(1);
                  end
               end else begin
                  mem_wr.we         = 1'b1;
                  mem_wr.addr       = cell_addr(row_ff, col_ff, top_ff);
                  mem_wr.data.code  = req_data.char_code;
                  mem_wr.data.color = attr_ff;
                  if (col_ff == COL_W'(COLUMNS - 1)) begin
                     col_in = '0;
                     row_in = (row_ff == ROW_W'(ROWS - 1)) ? '0 : row_ff + ROW_W'(1);
                  end else begin
                     col_in = col_ff + COL_W'(1);
                  end
               end
               if (req_data.action == ACTION_PUT) begin
                  push.valid           = 1'b1;
                  push.data.cursor_row = row_in;
                  push.data.cursor_col = col_in;
               end
            end
         end
         ST_RD_WAIT: begin
            push.valid           = 1'b1;
            push.data.cell_char  = rd_zero_ff ? 8'h00 : mem_rd_data.code;
            push.data.cell_color = rd_zero_ff ? 8'h00 : mem_rd_data.color;
            push.data.cursor_row = row_ff;
            push.data.cursor_col = col_ff;
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         row_ff       <= '0;
         col_ff       <= '0;
         top_ff       <= '0;
         attr_ff      <= RESET_COLOR;
         clr_cnt_ff   <= '0;
         clr_last_ff  <= ADDR_W'(CELL_COUNT - 1);
         clr_color_ff <= RESET_COLOR;
         rd_zero_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         attr_ff      <= attr_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_last_ff  <= clr_last_in;
         clr_color_ff <= clr_color_in;
         rd_zero_ff   <= rd_zero_in;
      end
   end

   `TCW_ASSERT(a_push_has_room, clock, reset, !push.valid || out_free)
   `TCW_ASSERT(a_wr_in_range, clock, reset, !mem_wr.we || (mem_wr.addr < ADDR_W'(CELL_COUNT)))
   `TCW_ASSERT(a_cursor_in_range, clock, reset,
      (row_ff < ROW_W'(ROWS)) && (col_ff < COL_W'(COLUMNS)) && (top_ff < ROW_W'(ROWS)))
   `TCW_ASSERT_NEXT(a_read_answers, clock, reset,
      accept && (req_data.action == ACTION_READ), push.valid)
   `TCW_ASSERT(a_no_rw_overlap, clock, reset, !(mem_wr.we && mem_rd.re))

endmodule

[rtl/text_console_char_writer.sv]
// text console character writer: 80x25 cell screen with cursor, scroll and cell read-back
// a put transaction's result is registered and valid in the cycle after acceptance; a read's passes
// through the memory read register and then the output register. Puts go one per cycle while rsp_ready holds
// newline on the bottom row rotates the row ring and then clears one row, holding req_ready low meanwhile
// reset: synchronous; a clearing pass writes every cell with space on 0x07,
// req_ready stays low until it ends
module text_console_char_writer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcw_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata
);
   import tcw_pkg::*;

   rsp_push_type push;
   mem_wr_type   mem_wr;
   mem_rd_type   mem_rd;
   cell_type     mem_rd_data;
   logic         out_free;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   // output register separates the result side from the sequencer
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   tcw_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .out_free    (out_free),
      .push        (push),
      .mem_wr      (mem_wr),
      .mem_rd      (mem_rd),
      .mem_rd_data (mem_rd_data)
   );

   tcw_screen_ram u_ram (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (mem_rd_data)
   );

endmodule
